@@ src/psc_pkg.sv @@
`default_nettype none
package psc_pkg;
    localparam int MAX_SEGMENTS = 256;
    localparam int ADDR_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int SEG_W = 192;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
endpackage
`default_nettype wire

@@ src/point_segment_clearance.sv @@
// point_segment_clearance
// Keeps a table of up to 256 3D segments and answers nearest-segment queries.
// Input channel (i_in_valid / o_in_ready): one transfer carries i_op and the
// coordinates. Clear and load give no result. A query gives one result on the
// output channel (o_out_valid / i_out_ready).
// A query walks the stored segments one after another through a single
// 33x33 multiplier, a bit-serial multiplier and a restoring divider.
// A segment whose nearest point is an endpoint skips the per-axis steps; when
// the projection is used, each axis takes 33 multiply steps, one rounding add
// and 34 divide steps. A final bit-pair square root follows the walk.
// A query on an empty table skips the walk and the square root, and any result
// may also wait for the output register.
// The block takes one item at a time; o_in_ready is high only while idle.
// A finished result waits in the output register; clears and loads are still
// taken while it waits, and a following query waits at its end for the slot.
// Reset (synchronous, active low) empties the table and clears the overflow
// flag and the output valid flag; segment memory is not cleared.
`default_nettype none
module point_segment_clearance
    import psc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic signed [31:0] i_ax,
    input  wire logic signed [31:0] i_ay,
    input  wire logic signed [31:0] i_az,
    input  wire logic signed [31:0] i_bx,
    input  wire logic signed [31:0] i_by,
    input  wire logic signed [31:0] i_bz,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_valid_res,
    output logic [31:0]      o_distance,
    output logic signed [31:0] o_near_x,
    output logic signed [31:0] o_near_y,
    output logic signed [31:0] o_near_z,
    output logic             o_overflowed
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_LAT  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_DEC  = 4'd4;
    localparam logic [3:0] S_MULS = 4'd5;
    localparam logic [3:0] S_ADDH = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_SQRT = 4'd9;
    localparam logic [3:0] S_WAIT = 4'd10;

    logic [3:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_k;
    logic             r_ovf;
    logic             r_have;

    logic signed [31:0] r_p [3];
    logic signed [31:0] r_a [3];
    logic signed [31:0] r_b [3];
    logic signed [31:0] r_c [3];
    logic signed [31:0] r_bc [3];
    logic signed [32:0] r_d [3];
    logic signed [32:0] r_w [3];
    logic signed [32:0] r_u [3];
    logic signed [67:0] r_acc [4];

    logic [1:0]         r_ax;
    logic [1:0]         r_grp;
    logic               r_mode;
    logic               r_idone;
    logic               r_pvld;
    logic               r_plast;
    logic [1:0]         r_ptgt;
    logic signed [65:0] r_prod;

    logic [65:0] r_dist;
    logic [65:0] r_best;
    logic [5:0]  r_bit;
    logic [98:0] r_num;
    logic [32:0] r_m;
    logic [33:0] r_nl;
    logic [65:0] r_rem;
    logic [33:0] r_q;
    logic [65:0] r_sn;
    logic [33:0] r_root;
    logic [34:0] r_srem;

    logic [SEG_W-1:0] w_rdata;
    logic             w_we;
    logic             w_acc_in;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc_in   = i_in_valid && o_in_ready;
    assign w_we       = w_acc_in && (i_op == OP_LOAD) && (r_count < CNT_W'(MAX_SEGMENTS));

    psc_ram #(.W(SEG_W), .D(MAX_SEGMENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_bz, i_by, i_bx, i_az, i_ay, i_ax}),
        .i_raddr (r_k[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // shared multiplier operands
    logic signed [32:0] w_op1, w_op2;
    logic signed [65:0] w_prod;
    always_comb begin
        case (r_grp)
            2'd0: begin w_op1 = r_d[r_ax]; w_op2 = r_d[r_ax]; end
            2'd1: begin w_op1 = r_d[r_ax]; w_op2 = r_w[r_ax]; end
            2'd2: begin w_op1 = r_w[r_ax]; w_op2 = r_w[r_ax]; end
            default: begin w_op1 = r_u[r_ax]; w_op2 = r_u[r_ax]; end
        endcase
    end
    assign w_prod = w_op1 * w_op2;

    logic        w_proj;
    logic [98:0] w_dot99;
    logic [98:0] w_half;
    logic [98:0] w_sum;
    logic [66:0] w_dt;
    logic        w_qb;
    logic [33:0] w_qfin;
    logic [35:0] w_cw;
    logic [31:0] w_cnew;
    logic [36:0] w_st;
    logic [36:0] w_trial;
    logic [34:0] w_rr;
    logic [31:0] w_dsat;

    assign w_proj  = (r_acc[0] != '0) && !r_acc[1][67] && (r_acc[1] <= r_acc[0]);
    assign w_dot99 = {33'd0, r_acc[1][65:0]};
    assign w_half  = {34'd0, r_acc[0][65:1]};
    assign w_sum   = r_num + w_half;
    assign w_dt    = {r_rem, r_nl[33]};
    assign w_qb    = (w_dt >= {1'b0, r_acc[0][65:0]});
    assign w_qfin  = {r_q[32:0], w_qb};
    always_comb begin
        if (r_d[r_ax][32]) begin
            w_cw = {{4{r_a[r_ax][31]}}, r_a[r_ax]} - {2'd0, w_qfin};
        end else begin
            w_cw = {{4{r_a[r_ax][31]}}, r_a[r_ax]} + {2'd0, w_qfin};
        end
    end
    assign w_cnew  = w_cw[31:0];
    assign w_st    = {r_srem, r_sn[65:64]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_rr    = ({1'b0, r_srem} > {2'b0, r_root}) ? 35'(r_root) + 35'd1 : 35'(r_root);
    assign w_dsat  = (w_rr[34:32] != 3'd0) ? 32'hFFFF_FFFF : w_rr[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            o_out_valid <= 1'b0;
            r_pvld      <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && (r_state != S_WAIT)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        case (i_op)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_ovf   <= 1'b0;
                            end
                            OP_LOAD: begin
                                if (r_count < CNT_W'(MAX_SEGMENTS)) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            OP_QUERY: begin
                                r_p[0] <= i_ax;
                                r_p[1] <= i_ay;
                                r_p[2] <= i_az;
                                r_k    <= '0;
                                r_have <= 1'b0;
                                for (int i = 0; i < 3; i++) r_bc[i] <= '0;
                                r_state <= (r_count == '0) ? S_WAIT : S_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: r_state <= S_LAT;
                S_LAT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_a[i] <= $signed(w_rdata[32*i +: 32]);
                        r_b[i] <= $signed(w_rdata[96 + 32*i +: 32]);
                        r_d[i] <= 33'($signed(w_rdata[96 + 32*i +: 32]))
                                - 33'($signed(w_rdata[32*i +: 32]));
                        r_w[i] <= 33'(r_p[i]) - 33'($signed(w_rdata[32*i +: 32]));
                        r_u[i] <= 33'(r_p[i]) - 33'($signed(w_rdata[96 + 32*i +: 32]));
                    end
                    for (int j = 0; j < 4; j++) r_acc[j] <= '0;
                    r_ax    <= 2'd0;
                    r_grp   <= 2'd0;
                    r_mode  <= 1'b0;
                    r_idone <= 1'b0;
                    r_pvld  <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (!r_idone) begin
                        r_prod  <= w_prod;
                        r_pvld  <= 1'b1;
                        r_ptgt  <= r_mode ? 2'd2 : r_grp;
                        r_plast <= (r_ax == 2'd2) && (r_grp == 2'd3);
                        if (r_ax == 2'd2) begin
                            r_ax <= 2'd0;
                            if (r_grp == 2'd3) begin
                                r_idone <= 1'b1;
                            end else begin
                                r_grp <= r_grp + 1'b1;
                            end
                        end else begin
                            r_ax <= r_ax + 1'b1;
                        end
                    end else begin
                        r_pvld <= 1'b0;
                    end
                    if (r_pvld) begin
                        r_acc[r_ptgt] <= r_acc[r_ptgt] + {{2{r_prod[65]}}, r_prod};
                        if (r_plast) begin
                            if (r_mode) begin
                                r_dist  <= 66'(r_acc[2] + {{2{r_prod[65]}}, r_prod});
                                r_state <= S_CMP;
                            end else begin
                                r_state <= S_DEC;
                            end
                        end
                    end
                end
                S_DEC: begin
                    r_ax <= 2'd0;
                    if (w_proj) begin
                        r_num   <= '0;
                        r_m     <= r_d[0][32] ? 33'(-r_d[0]) : 33'(r_d[0]);
                        r_bit   <= 6'd32;
                        r_state <= S_MULS;
                    end else begin
                        if (r_acc[2] < r_acc[3]) begin
                            for (int i = 0; i < 3; i++) r_c[i] <= r_a[i];
                            r_dist <= r_acc[2][65:0];
                        end else begin
                            for (int i = 0; i < 3; i++) r_c[i] <= r_b[i];
                            r_dist <= r_acc[3][65:0];
                        end
                        r_state <= S_CMP;
                    end
                end
                S_MULS: begin
                    r_num <= (r_num << 1) + (r_m[32] ? w_dot99 : 99'd0);
                    r_m   <= r_m << 1;
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 6'd0) begin
                        r_state <= S_ADDH;
                    end
                end
                S_ADDH: begin
                    r_rem   <= {1'b0, w_sum[98:34]};
                    r_nl    <= w_sum[33:0];
                    r_q     <= '0;
                    r_bit   <= 6'd33;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_nl  <= r_nl << 1;
                    r_q   <= w_qfin;
                    r_rem <= w_qb ? 66'(w_dt - {1'b0, r_acc[0][65:0]}) : w_dt[65:0];
                    if (r_bit != 6'd0) begin
                        r_bit <= r_bit - 1'b1;
                    end else begin
                        // end of one divide: place the rounded coordinate and go on
                        r_c[r_ax] <= w_cnew;
                        r_u[r_ax] <= 33'(r_p[r_ax]) - 33'($signed(w_cnew));
                        if (r_ax == 2'd2) begin
                            r_ax     <= 2'd0;
                            r_grp    <= 2'd3;
                            r_mode   <= 1'b1;
                            r_idone  <= 1'b0;
                            r_pvld   <= 1'b0;
                            r_acc[2] <= '0;
                            r_state  <= S_MUL;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_num   <= '0;
                            r_m     <= r_d[r_ax + 1'b1][32] ? 33'(-r_d[r_ax + 1'b1])
                                                            : 33'(r_d[r_ax + 1'b1]);
                            r_bit   <= 6'd32;
                            r_state <= S_MULS;
                        end
                    end
                end
                S_CMP: begin
                    if (!r_have || (r_dist < r_best)) begin
                        r_have <= 1'b1;
                        r_best <= r_dist;
                        for (int i = 0; i < 3; i++) r_bc[i] <= r_c[i];
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k + 1'b1 == r_count) begin
                        r_sn    <= (!r_have || (r_dist < r_best)) ? r_dist : r_best;
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_bit   <= 6'd32;
                        r_state <= S_SQRT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_SQRT: begin
                    r_sn  <= r_sn << 2;
                    r_bit <= r_bit - 1'b1;
                    if (w_st >= w_trial) begin
                        r_srem <= 35'(w_st - w_trial);
                        r_root <= {r_root[32:0], 1'b1};
                    end else begin
                        r_srem <= w_st[34:0];
                        r_root <= {r_root[32:0], 1'b0};
                    end
                    if (r_bit == 6'd0) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid  <= 1'b1;
                        o_valid_res  <= r_have;
                        o_distance   <= r_have ? w_dsat : 32'd0;
                        o_near_x     <= r_bc[0];
                        o_near_y     <= r_bc[1];
                        o_near_z     <= r_bc[2];
                        o_overflowed <= r_ovf;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/psc_ram.sv @@
`default_nettype none
module psc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ dv/point_segment_clearance_checker.sv @@
`default_nettype none
module point_segment_clearance_checker
    import psc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic signed [31:0] i_ax,
    input  wire logic signed [31:0] i_ay,
    input  wire logic signed [31:0] i_az,
    input  wire logic signed [31:0] i_bx,
    input  wire logic signed [31:0] i_by,
    input  wire logic signed [31:0] i_bz,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_valid_res,
    input  wire logic [31:0] i_distance,
    input  wire logic signed [31:0] i_near_x,
    input  wire logic signed [31:0] i_near_y,
    input  wire logic signed [31:0] i_near_z,
    input  wire logic        i_overflowed,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] distance;
        logic [31:0] near_x;
        logic [31:0] near_y;
        logic [31:0] near_z;
        logic        overflowed;
    } t_clearance;

    typedef logic signed [127:0] t_wide;

    logic signed [31:0] seg_a [MAX_SEGMENTS][3];
    logic signed [31:0] seg_b [MAX_SEGMENTS][3];
    int unsigned        seg_count;
    logic               ovf_flag;
    t_clearance         clearance_q[$];

    function automatic logic [31:0] round_sqrt(input logic [127:0] n);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int b = 40; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= n) r = c;
        end
        if (n - r * r > r) r = r + 1;
        return (r > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic t_clearance nearest_segment(input logic signed [31:0] px,
                                                   input logic signed [31:0] py,
                                                   input logic signed [31:0] pz);
        t_clearance res;
        t_wide p[3], a[3], b[3], d[3], c[3], best_c[3];
        t_wide len2, dot, sq_dist, da, db, best, m, num, s;
        logic have;
        p[0] = px; p[1] = py; p[2] = pz;
        have = 0;
        best = 0;
        for (int i = 0; i < 3; i++) best_c[i] = 0;
        for (int k = 0; k < seg_count; k++) begin
            len2 = 0;
            dot = 0;
            da = 0;
            db = 0;
            for (int i = 0; i < 3; i++) begin
                a[i] = seg_a[k][i];
                b[i] = seg_b[k][i];
                d[i] = b[i] - a[i];
                len2 = len2 + d[i] * d[i];
                dot = dot + d[i] * (p[i] - a[i]);
                da = da + (p[i] - a[i]) * (p[i] - a[i]);
                db = db + (p[i] - b[i]) * (p[i] - b[i]);
            end
            if (len2 != 0 && dot >= 0 && dot <= len2) begin
                sq_dist = 0;
                for (int i = 0; i < 3; i++) begin
                    m = (d[i] < 0) ? -d[i] : d[i];
                    num = m * dot + (len2 >>> 1);
                    s = $signed($unsigned(num) / $unsigned(len2));
                    c[i] = (d[i] < 0) ? a[i] - s : a[i] + s;
                    sq_dist = sq_dist + (p[i] - c[i]) * (p[i] - c[i]);
                end
            end else if (da < db) begin
                for (int i = 0; i < 3; i++) c[i] = a[i];
                sq_dist = da;
            end else begin
                for (int i = 0; i < 3; i++) c[i] = b[i];
                sq_dist = db;
            end
            if (!have || sq_dist < best) begin
                have = 1;
                best = sq_dist;
                for (int i = 0; i < 3; i++) best_c[i] = c[i];
            end
        end
        res.valid_res  = have;
        res.distance   = have ? round_sqrt(best) : 32'd0;
        res.near_x     = best_c[0][31:0];
        res.near_y     = best_c[1][31:0];
        res.near_z     = best_c[2][31:0];
        res.overflowed = ovf_flag;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, field, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        seg_count = 0;
        ovf_flag = 0;
    end

    assign o_pending = clearance_q.size();

    always @(posedge i_clk) begin
        t_clearance want;
        if (!i_rst_n) begin
            seg_count = 0;
            ovf_flag = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                case (i_op)
                    OP_CLEAR: begin
                        seg_count = 0;
                        ovf_flag = 0;
                    end
                    OP_LOAD: begin
                        if (seg_count < MAX_SEGMENTS) begin
                            seg_a[seg_count] = '{i_ax, i_ay, i_az};
                            seg_b[seg_count] = '{i_bx, i_by, i_bz};
                            seg_count++;
                        end else begin
                            ovf_flag = 1;
                        end
                    end
                    OP_QUERY: clearance_q.insert(clearance_q.size(),
                                                 nearest_segment(i_ax, i_ay, i_az));
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (clearance_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    want = clearance_q.pop_front();
                    if (i_valid_res !== want.valid_res)
                        report_mismatch("valid_res", i_valid_res, want.valid_res);
                    if (i_distance !== want.distance)
                        report_mismatch("distance", i_distance, want.distance);
                    if (i_near_x !== want.near_x)
                        report_mismatch("near_x", i_near_x, want.near_x);
                    if (i_near_y !== want.near_y)
                        report_mismatch("near_y", i_near_y, want.near_y);
                    if (i_near_z !== want.near_z)
                        report_mismatch("near_z", i_near_z, want.near_z);
                    if (i_overflowed !== want.overflowed)
                        report_mismatch("overflowed", i_overflowed, want.overflowed);
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ dv/point_segment_clearance_tb.sv @@
`default_nettype none
module point_segment_clearance_tb;
    import psc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 300000;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [1:0] i_op;
    logic signed [31:0] i_ax, i_ay, i_az, i_bx, i_by, i_bz;
    logic o_out_valid;
    logic i_out_ready;
    logic o_valid_res;
    logic [31:0] o_distance;
    logic signed [31:0] o_near_x, o_near_y, o_near_z;
    logic o_overflowed;
    int errors;
    int pending;
    int sent;
    int idle_cycles;
    logic quiet;

    point_segment_clearance i_dut (.*);

    point_segment_clearance_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_op(i_op), .i_ax(i_ax), .i_ay(i_ay), .i_az(i_az), .i_bx(i_bx), .i_by(i_by),
        .i_bz(i_bz), .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_valid_res(o_valid_res), .i_distance(o_distance), .i_near_x(o_near_x),
        .i_near_y(o_near_y), .i_near_z(o_near_z), .i_overflowed(o_overflowed),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver stalls in short bursts
    initial begin
        i_out_ready = 1;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
                i_out_ready <= 1;
            end
        end
    end

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 9) < 7) return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
        return $signed($urandom);
    endfunction

    task automatic transfer(input logic [1:0] op,
                            input logic signed [31:0] ax, input logic signed [31:0] ay,
                            input logic signed [31:0] az, input logic signed [31:0] bx,
                            input logic signed [31:0] by, input logic signed [31:0] bz);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid = 0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid = 1;
        i_op = op;
        i_ax = ax; i_ay = ay; i_az = az;
        i_bx = bx; i_by = by; i_bz = bz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid = 0;
        sent++;
    endtask

    task automatic load_random();
        transfer(OP_LOAD, rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic query_random();
        transfer(OP_QUERY, rand_coord(), rand_coord(), rand_coord(),
                 $signed($urandom), $signed($urandom), $signed($urandom));
    endtask

    initial begin
        int n;
        quiet = 0;
        sent = 0;
        idle_cycles = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_op = OP_CLEAR;
        {i_ax, i_ay, i_az, i_bx, i_by, i_bz} = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // empty table, then extremes and corner cases
        transfer(OP_QUERY, 1, 2, 3, 0, 0, 0);
        transfer(OP_LOAD, 0, 0, 0, 1, 1, 0);
        transfer(OP_QUERY, 1, 0, 0, 0, 0, 0);
        transfer(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        transfer(OP_LOAD, 0, 0, 0, -1, -1, 0);
        transfer(OP_QUERY, -1, 0, 0, 0, 0, 0);
        transfer(OP_LOAD, 5, 5, 5, 5, 5, 5);
        transfer(OP_QUERY, 9, 9, 9, MAXV, MINV, MAXV);
        transfer(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        transfer(OP_LOAD, 0, 0, 0, 0, 0, 65536);
        transfer(OP_LOAD, 10, 0, 0, 10, 0, 65536);
        transfer(OP_QUERY, 5, 0, 0, 0, 0, 0);
        transfer(OP_QUERY, 5, 0, -7, 0, 0, 0);
        transfer(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        transfer(OP_LOAD, MINV, MINV, MINV, MINV, MINV, MINV);
        transfer(OP_QUERY, MAXV, MAXV, MAXV, 0, 0, 0);
        transfer(OP_LOAD, MINV, MAXV, MINV, MAXV, MINV, MAXV);
        transfer(OP_QUERY, 0, 0, 0, 0, 0, 0);
        transfer(OP_QUERY, MAXV, MINV, 0, 0, 0, 0);
        transfer(OP_UNUSED, 1, 2, 3, 4, 5, 6);
        transfer(OP_QUERY, -1, -1, -1, -1, -1, -1);

        // sender holds off until all results are back
        wait (pending == 0);
        @(negedge i_clk);

        // overflow: fill past capacity
        transfer(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        repeat (MAX_SEGMENTS + 2) load_random();
        query_random();
        transfer(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        query_random();

        while (sent < 1040) begin
            if (sent > 900) quiet = 1;
            if ($urandom_range(0, 3) != 0) transfer(OP_CLEAR, 0, 0, 0, 0, 0, 0);
            n = $urandom_range(1, 6);
            repeat (n) load_random();
            n = $urandom_range(2, 8);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0: transfer(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom);
                    1: transfer(OP_UNUSED, rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord());
                    default: query_random();
                endcase
            end
        end

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
src/psc_pkg.sv
src/psc_ram.sv
src/point_segment_clearance.sv
dv/point_segment_clearance_checker.sv
dv/point_segment_clearance_tb.sv
